// File: rtl/cse_pkg.sv
// ----------------------------------------------------------------------------
// cse_pkg
// Shared types, codes and defaults of the counting sort engine.
// ----------------------------------------------------------------------------
package cse_pkg;

  // defaults for the top level parameters
  localparam int DEF_VALUE_BINS = 1024;
  localparam int DEF_COUNT_BITS = 16;

  // fixed field widths
  localparam int VALUE_W    = 10;
  localparam int CFG_DATA_W = 10;
  localparam int CFG_IDX_W  = 2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_VALUE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DESCENDING = 2'd1;

  localparam logic [VALUE_W-1:0] MAX_VALUE_RESET = 10'd1023;

  // queue depths
  localparam int CMD_QUEUE_DEPTH = 2;
  localparam int RES_QUEUE_DEPTH = 2;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_FETCH  = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_ABOVE_MAX = 2'd1,
    STAT_SATURATED = 2'd2,
    STAT_EMPTY     = 2'd3
  } status_t;

  // command classes handed from the front to the back
  typedef enum logic [1:0] {
    CMD_REJECT = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_FETCH  = 2'd2
  } cmd_kind_t;

  // back end sequencer
  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_INS,
    S_SCAN,
    S_LAST,
    S_RESULT
  } state_t;

  typedef struct packed {
    logic [VALUE_W-1:0] sorted_value;
    status_t            status;
    logic               last;
  } res_t;

endpackage

// File: rtl/cse_ram.sv
// ----------------------------------------------------------------------------
// cse_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module cse_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/cse_fifo.sv
// ----------------------------------------------------------------------------
// cse_fifo
// Small register queue with push/full and pop/empty sides.
// ----------------------------------------------------------------------------
module cse_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  // handshake qualification
  assign full    = (count == CNT_FULL);
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = slots[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wdata;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: rtl/cse_front.sv
// ----------------------------------------------------------------------------
// cse_front
// Accepts items, classifies them against the top bin and queues commands.
// ----------------------------------------------------------------------------
module cse_front #(
  parameter int VALUE_BINS = cse_pkg::DEF_VALUE_BINS
) (
  input  logic                          clk,
  input  logic                          rst,
  // item side
  input  logic                          push,
  output logic                          full,
  input  logic                          opcode,
  input  logic [cse_pkg::VALUE_W-1:0]   value,
  // configuration and back end status
  input  logic [$clog2(VALUE_BINS)-1:0] top,
  input  logic                          clearing,
  // command side
  output logic                          cmd_valid,
  input  logic                          cmd_pop,
  output cse_pkg::cmd_kind_t            cmd_kind,
  output logic [$clog2(VALUE_BINS)-1:0] cmd_addr
);

  localparam int ADDR_W = $clog2(VALUE_BINS);
  localparam int CMD_W  = 2 + ADDR_W;

  cse_pkg::cmd_kind_t kind;
  logic [31:0]        value_wide;
  logic [ADDR_W-1:0]  addr;
  logic               q_full;
  logic               q_empty;
  logic [CMD_W-1:0]   q_rdata;

  // classify the incoming item
  always_comb begin
    value_wide = 32'(value);
    addr       = value_wide[ADDR_W-1:0];
    if (cse_pkg::op_t'(opcode) == cse_pkg::OP_FETCH) begin
      kind = cse_pkg::CMD_FETCH;
    end else if (value_wide > 32'(top)) begin
      kind = cse_pkg::CMD_REJECT;
    end else begin
      kind = cse_pkg::CMD_INSERT;
    end
  end

  // no items while the bin store is being cleared
  assign full = q_full || clearing;

  // command queue between front and back
  cse_fifo #(
    .WIDTH (CMD_W),
    .DEPTH (cse_pkg::CMD_QUEUE_DEPTH)
  ) u_cmd_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push && !full),
    .wdata ({kind, addr}),
    .full  (q_full),
    .pop   (cmd_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  assign cmd_valid = !q_empty;
  assign cmd_kind  = cse_pkg::cmd_kind_t'(q_rdata[CMD_W-1:ADDR_W]);
  assign cmd_addr  = q_rdata[ADDR_W-1:0];

endmodule

// File: rtl/cse_back.sv
// ----------------------------------------------------------------------------
// cse_back
// Executes commands on the histogram: insert read-modify-write, fetch scan
// with look-ahead for the last flag, and the clearing sweep after reset.
// ----------------------------------------------------------------------------
module cse_back #(
  parameter int VALUE_BINS = cse_pkg::DEF_VALUE_BINS,
  parameter int COUNT_BITS = cse_pkg::DEF_COUNT_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  // configuration
  input  logic [$clog2(VALUE_BINS)-1:0] top,
  input  logic                          descending,
  input  logic                          cfg_write,
  input  logic [$clog2(VALUE_BINS)-1:0] cfg_start,
  // command side
  input  logic                          cmd_valid,
  output logic                          cmd_pop,
  input  cse_pkg::cmd_kind_t            cmd_kind,
  input  logic [$clog2(VALUE_BINS)-1:0] cmd_addr,
  // result side
  output logic                          res_push,
  output cse_pkg::res_t                 res,
  input  logic                          res_full,
  // status
  output logic                          clearing
);

  localparam int ADDR_W = $clog2(VALUE_BINS);
  localparam logic [ADDR_W-1:0] BIN_LAST = ADDR_W'(VALUE_BINS - 1);

  cse_pkg::state_t   state;
  cse_pkg::state_t   state_next;
  logic [ADDR_W-1:0] clr_addr;
  logic [ADDR_W-1:0] clr_addr_next;
  logic [ADDR_W-1:0] idx;
  logic [ADDR_W-1:0] idx_next;
  logic [ADDR_W-1:0] cursor;
  logic [ADDR_W-1:0] cursor_next;
  cse_pkg::res_t     res_next;

  logic                  ram_we;
  logic [ADDR_W-1:0]     ram_waddr;
  logic [COUNT_BITS-1:0] ram_wdata;
  logic [ADDR_W-1:0]     ram_raddr;
  logic [COUNT_BITS-1:0] bin;

  logic              start_ok;
  logic              at_end;
  logic [ADDR_W-1:0] idx_step;
  logic [ADDR_W-1:0] start_bin;
  logic              bin_zero;
  logic              bin_one;
  logic              bin_full;
  logic [31:0]       idx_wide;

  // shared decode
  assign start_ok  = cmd_valid && ((state == cse_pkg::S_IDLE) ||
                     ((state == cse_pkg::S_RESULT) && !res_full));
  assign at_end    = descending ? (idx == '0) : (idx == top);
  assign idx_step  = descending ? idx - 1'b1 : idx + 1'b1;
  assign start_bin = descending ? top : '0;
  assign bin_zero  = (bin == '0);
  assign bin_one   = (bin == COUNT_BITS'(1));
  assign bin_full  = (bin == '1);
  assign idx_wide  = 32'(idx);
  assign clearing  = (state == cse_pkg::S_CLEAR);

  // histogram store
  cse_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (VALUE_BINS)
  ) u_bins (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (bin)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      cse_pkg::S_CLEAR: begin
        if (clr_addr == BIN_LAST) begin
          state_next = cse_pkg::S_IDLE;
        end
      end
      cse_pkg::S_IDLE, cse_pkg::S_RESULT: begin
        if ((state == cse_pkg::S_RESULT) && res_full) begin
          state_next = cse_pkg::S_RESULT;
        end else if (cmd_valid) begin
          unique case (cmd_kind)
            cse_pkg::CMD_INSERT: state_next = cse_pkg::S_INS;
            cse_pkg::CMD_FETCH:  state_next = cse_pkg::S_SCAN;
            default:             state_next = cse_pkg::S_RESULT;
          endcase
        end else begin
          state_next = cse_pkg::S_IDLE;
        end
      end
      cse_pkg::S_INS: begin
        state_next = cse_pkg::S_RESULT;
      end
      cse_pkg::S_SCAN: begin
        if (!bin_zero) begin
          state_next = (bin_one && !at_end) ? cse_pkg::S_LAST : cse_pkg::S_RESULT;
        end else if (at_end) begin
          state_next = cse_pkg::S_RESULT;
        end
      end
      cse_pkg::S_LAST: begin
        if (!bin_zero || at_end) begin
          state_next = cse_pkg::S_RESULT;
        end
      end
      default: state_next = cse_pkg::S_CLEAR;
    endcase
  end

  // datapath control
  always_comb begin
    ram_we        = 1'b0;
    ram_waddr     = idx;
    ram_wdata     = bin;
    ram_raddr     = idx_step;
    cmd_pop       = 1'b0;
    res_push      = 1'b0;
    idx_next      = idx;
    cursor_next   = cursor;
    res_next      = res;
    clr_addr_next = clr_addr;
    unique case (state)
      cse_pkg::S_CLEAR: begin
        ram_we        = 1'b1;
        ram_waddr     = clr_addr;
        ram_wdata     = '0;
        clr_addr_next = clr_addr + 1'b1;
      end
      cse_pkg::S_IDLE, cse_pkg::S_RESULT: begin
        // hand over the finished transaction, then start the next command
        res_push = (state == cse_pkg::S_RESULT) && !res_full;
        if (start_ok) begin
          cmd_pop = 1'b1;
          unique case (cmd_kind)
            cse_pkg::CMD_INSERT: begin
              ram_raddr = cmd_addr;
              idx_next  = cmd_addr;
            end
            cse_pkg::CMD_FETCH: begin
              ram_raddr = cursor;
              idx_next  = cursor;
            end
            default: begin
              res_next.sorted_value = '0;
              res_next.status       = cse_pkg::STAT_ABOVE_MAX;
              res_next.last         = 1'b0;
            end
          endcase
        end
      end
      cse_pkg::S_INS: begin
        res_next.sorted_value = '0;
        res_next.last         = 1'b0;
        if (bin_full) begin
          res_next.status = cse_pkg::STAT_SATURATED;
        end else begin
          ram_we          = 1'b1;
          ram_wdata       = bin + 1'b1;
          cursor_next     = start_bin;
          res_next.status = cse_pkg::STAT_OK;
        end
      end
      cse_pkg::S_SCAN: begin
        if (!bin_zero) begin
          // hit: take one count and look ahead for the last flag
          ram_we                = 1'b1;
          ram_wdata             = bin - 1'b1;
          cursor_next           = idx;
          idx_next              = idx_step;
          res_next.sorted_value = idx_wide[cse_pkg::VALUE_W-1:0];
          res_next.status       = cse_pkg::STAT_OK;
          res_next.last         = bin_one && at_end;
        end else if (at_end) begin
          res_next.sorted_value = '0;
          res_next.status       = cse_pkg::STAT_EMPTY;
          res_next.last         = 1'b0;
          cursor_next           = descending ? '0 : top;
        end else begin
          idx_next = idx_step;
        end
      end
      cse_pkg::S_LAST: begin
        if (!bin_zero) begin
          res_next.last = 1'b0;
        end else if (at_end) begin
          res_next.last = 1'b1;
        end else begin
          idx_next = idx_step;
        end
      end
      default: begin
        clr_addr_next = '0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= cse_pkg::S_CLEAR;
      clr_addr <= '0;
      cursor   <= '0;
    end else begin
      state    <= state_next;
      clr_addr <= clr_addr_next;
      cursor   <= cfg_write ? cfg_start : cursor_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    idx <= idx_next;
    res <= res_next;
  end

  // checks
  a_no_pop_in_clear : assert property (@(posedge clk) disable iff (rst)
    (state == cse_pkg::S_CLEAR) |-> !cmd_pop)
    else $error("command taken during clearing sweep");

  a_no_write_at_rest : assert property (@(posedge clk) disable iff (rst)
    ((state == cse_pkg::S_IDLE) || (state == cse_pkg::S_RESULT)) |-> !ram_we)
    else $error("bin store written outside a command");

  a_push_from_result : assert property (@(posedge clk) disable iff (rst)
    res_push |-> ((state == cse_pkg::S_RESULT) && !res_full))
    else $error("result pushed outside result state");

  a_cfg_cursor : assert property (@(posedge clk) disable iff (rst)
    cfg_write |=> (cursor == $past(cfg_start)))
    else $error("cursor not moved to start bin on register write");

  a_last_entry : assert property (@(posedge clk) disable iff (rst)
    (state == cse_pkg::S_LAST) |->
      (($past(state) == cse_pkg::S_SCAN) || ($past(state) == cse_pkg::S_LAST)))
    else $error("look-ahead entered without a hit");

endmodule

// File: rtl/counting_sort_engine.sv
// ----------------------------------------------------------------------------
// counting_sort_engine
// Histogram based counting sort: inserts count values, fetches return them
// in ascending or descending order with a flag on the final value.
// ----------------------------------------------------------------------------
//
//  port group    direction  handshake      payload
//  items         in         push / full    opcode, value
//  results       out        empty / pop    sorted_value, status, last
//  registers     in         cfg_we         cfg_index, cfg_wdata
//
//  An insert reads its bin and writes it back through the bin RAM.
//  A fetch reads every bin that the scan passes over,
//  including the bins after the hit checked for the last flag; the single
//  RAM read port visits one bin per cycle.
//  After reset a clearing sweep zeroes every bin of the bin store,
//  with full held high; register writes are taken during it.
//  Command and result queues of two entries let the front accept items
//  while a result waits to be popped.
//
module counting_sort_engine #(
  parameter int VALUE_BINS = cse_pkg::DEF_VALUE_BINS,
  parameter int COUNT_BITS = cse_pkg::DEF_COUNT_BITS
) (
  input  logic                             clk,
  input  logic                             rst,
  // items
  input  logic                             push,
  output logic                             full,
  input  logic                             opcode,
  input  logic [cse_pkg::VALUE_W-1:0]      value,
  // results
  output logic                             empty,
  input  logic                             pop,
  output logic [cse_pkg::VALUE_W-1:0]      sorted_value,
  output logic [1:0]                       status,
  output logic                             last,
  // registers
  input  logic                             cfg_we,
  input  logic [cse_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [cse_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  localparam int ADDR_W = $clog2(VALUE_BINS);
  localparam int RES_W  = $bits(cse_pkg::res_t);
  localparam logic [31:0] BIN_LAST = 32'(VALUE_BINS - 1);

  logic [cse_pkg::VALUE_W-1:0] max_value;
  logic [cse_pkg::VALUE_W-1:0] max_value_next;
  logic                        descending;
  logic                        descending_next;
  logic                        cfg_write;
  logic [ADDR_W-1:0]           top;
  logic [ADDR_W-1:0]           top_next;
  logic [ADDR_W-1:0]           cfg_start;

  logic                        clearing;
  logic                        cmd_valid;
  logic                        cmd_pop;
  cse_pkg::cmd_kind_t          cmd_kind;
  logic [ADDR_W-1:0]           cmd_addr;
  logic                        res_push;
  cse_pkg::res_t               res;
  logic                        res_full;
  logic [RES_W-1:0]            res_rdata;
  cse_pkg::res_t               res_out;

  // top bin in use: smaller of max_value and the last bin
  function automatic logic [ADDR_W-1:0] top_of(input logic [cse_pkg::VALUE_W-1:0] mv);
    logic [31:0] mv_wide;
    logic [31:0] t;
    mv_wide = 32'(mv);
    t       = (mv_wide < BIN_LAST) ? mv_wide : BIN_LAST;
    return t[ADDR_W-1:0];
  endfunction

  // register write decode
  always_comb begin
    max_value_next  = max_value;
    descending_next = descending;
    cfg_write       = 1'b0;
    if (cfg_we) begin
      unique case (cfg_index)
        cse_pkg::CFG_MAX_VALUE: begin
          max_value_next = cfg_wdata;
          cfg_write      = 1'b1;
        end
        cse_pkg::CFG_DESCENDING: begin
          descending_next = cfg_wdata[0];
          cfg_write       = 1'b1;
        end
        default: begin
          cfg_write = 1'b0;
        end
      endcase
    end
  end

  // start bin that follows the written values
  assign top       = top_of(max_value);
  assign top_next  = top_of(max_value_next);
  assign cfg_start = descending_next ? top_next : '0;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      max_value  <= cse_pkg::MAX_VALUE_RESET;
      descending <= 1'b0;
    end else begin
      max_value  <= max_value_next;
      descending <= descending_next;
    end
  end

  // front: accept and classify
  cse_front #(
    .VALUE_BINS (VALUE_BINS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .opcode    (opcode),
    .value     (value),
    .top       (top),
    .clearing  (clearing),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop),
    .cmd_kind  (cmd_kind),
    .cmd_addr  (cmd_addr)
  );

  // back: histogram operations
  cse_back #(
    .VALUE_BINS (VALUE_BINS),
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .top        (top),
    .descending (descending),
    .cfg_write  (cfg_write),
    .cfg_start  (cfg_start),
    .cmd_valid  (cmd_valid),
    .cmd_pop    (cmd_pop),
    .cmd_kind   (cmd_kind),
    .cmd_addr   (cmd_addr),
    .res_push   (res_push),
    .res        (res),
    .res_full   (res_full),
    .clearing   (clearing)
  );

  // result queue
  cse_fifo #(
    .WIDTH (RES_W),
    .DEPTH (cse_pkg::RES_QUEUE_DEPTH)
  ) u_res_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .wdata (res),
    .full  (res_full),
    .pop   (pop),
    .rdata (res_rdata),
    .empty (empty)
  );

  assign res_out      = cse_pkg::res_t'(res_rdata);
  assign sorted_value = res_out.sorted_value;
  assign status       = res_out.status;
  assign last         = res_out.last;

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the counting sort engine. A queue of insert and
// fetch transactions feeds a driver; a monitor mirrors every accepted item
// into a histogram predictor and checks each popped result against the
// oldest prediction. Phases change the top value and the scan order, and
// vary sender and receiver idling.
// ----------------------------------------------------------------------------
module tb_top;
  import cse_pkg::*;

  // block built with its default bin count and count width
  localparam int BINS      = DEF_VALUE_BINS;
  localparam int CNT_W     = DEF_COUNT_BITS;
  localparam int WDOG_MAX  = 60000;

  // register indexes outside the map
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_HI = 2'd3;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  typedef struct {
    op_t                op;
    logic [VALUE_W-1:0] val;
  } sort_cmd_t;

  logic                  clk;
  logic                  rst;
  logic                  push;
  logic                  full;
  logic                  opcode;
  logic [VALUE_W-1:0]    value;
  logic                  empty;
  logic                  pop;
  logic [VALUE_W-1:0]    sorted_value;
  logic [1:0]            status;
  logic                  last;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  sort_cmd_t  pending_items[$];
  res_t       expected_results[$];
  int         items_queued;
  int         items_accepted;
  int         error_count;
  int         quiet_cycles;
  bit         item_taken;
  idle_mode_t idle_mode;

  // predictor state
  logic [CNT_W-1:0]   bin_tally [BINS];
  int                 scan_at;
  logic [VALUE_W-1:0] top_reg;
  logic               desc_reg;

  counting_sort_engine #(
    .VALUE_BINS (BINS),
    .COUNT_BITS (CNT_W)
  ) DUT (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .opcode       (opcode),
    .value        (value),
    .empty        (empty),
    .pop          (pop),
    .sorted_value (sorted_value),
    .status       (status),
    .last         (last),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // histogram predictor
  // ---------------------------------------------------------------------------
  function automatic int top_bin();
    return (int'(top_reg) < BINS - 1) ? int'(top_reg) : BINS - 1;
  endfunction

  function automatic int start_bin();
    return desc_reg ? top_bin() : 0;
  endfunction

  // first occupied bin from a start point in the scan direction
  function automatic bit find_bin(input int from, output int hit);
    int top;
    int i;
    top = top_bin();
    hit = 0;
    if (desc_reg) begin
      if (from > top) from = top;
      for (i = from; i >= 0; i--)
        if (bin_tally[i] != '0) begin
          hit = i;
          return 1'b1;
        end
      return 1'b0;
    end
    for (i = from; i <= top; i++)
      if (bin_tally[i] != '0) begin
        hit = i;
        return 1'b1;
      end
    return 1'b0;
  endfunction

  function automatic res_t sort_outcome(input op_t op, input logic [VALUE_W-1:0] v);
    res_t r;
    int   top;
    int   hit;
    int   nxt;
    r = '{sorted_value: '0, status: STAT_OK, last: 1'b0};
    top = top_bin();
    if (op == OP_INSERT) begin
      if (int'(v) > top) r.status = STAT_ABOVE_MAX;
      else if (bin_tally[v] == {CNT_W{1'b1}}) r.status = STAT_SATURATED;
      else begin
        bin_tally[v] = bin_tally[v] + 1'b1;
        scan_at = start_bin();
      end
    end else if (!desc_reg && scan_at > top) begin
      r.status = STAT_EMPTY;
    end else if (!find_bin(scan_at, hit)) begin
      r.status = STAT_EMPTY;
      scan_at = desc_reg ? 0 : top;
    end else begin
      r.sorted_value = VALUE_W'(hit);
      bin_tally[hit] = bin_tally[hit] - 1'b1;
      scan_at = hit;
      r.last = !find_bin(hit, nxt);
    end
    return r;
  endfunction

  function automatic void note_reg_write(input logic [CFG_IDX_W-1:0] idx,
                                         input logic [CFG_DATA_W-1:0] data);
    if (idx == CFG_MAX_VALUE) top_reg = data;
    else if (idx == CFG_DESCENDING) desc_reg = data[0];
    else return;
    scan_at = start_bin();
  endfunction

  // ---------------------------------------------------------------------------
  // idling
  // ---------------------------------------------------------------------------
  function automatic bit sender_idles();
    case (idle_mode)
      IDLE_SENDER: return $urandom_range(99) < 55;
      IDLE_BOTH:   return $urandom_range(99) < 11;
      default:     return 1'b0;
    endcase
  endfunction

  function automatic bit receiver_stalls();
    case (idle_mode)
      IDLE_RECEIVER: return $urandom_range(99) < 55;
      IDLE_BOTH:     return $urandom_range(99) < 11;
      default:       return 1'b0;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // driver: items and pop change on the falling edge
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    sort_cmd_t cmd;
    if (rst) begin
      push <= 1'b0;
      pop  <= 1'b0;
    end else begin
      if (!push || item_taken) begin
        if (pending_items.size() != 0 && !sender_idles()) begin
          cmd = pending_items.pop_front();
          push   <= 1'b1;
          opcode <= cmd.op;
          value  <= cmd.val;
        end else begin
          push <= 1'b0;
        end
      end
      pop <= !receiver_stalls();
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: results checked, items predicted, watchdog
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    res_t want;
    bit   moved;
    if (!rst) begin
      moved = 1'b0;
      // result transaction
      if (pop && !empty) begin
        moved = 1'b1;
        if (expected_results.size() == 0) begin
          $error("result with nothing expected: sorted_value %0d status %0d last %0d",
                 sorted_value, status, last);
          error_count++;
        end else begin
          want = expected_results.pop_front();
          if (sorted_value !== want.sorted_value) begin
            $error("sorted_value: expected %0d, got %0d", want.sorted_value, sorted_value);
            error_count++;
          end
          if (status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status);
            error_count++;
          end
          if (last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, last);
            error_count++;
          end
        end
      end
      // item transaction
      item_taken = push && !full;
      if (item_taken) begin
        moved = 1'b1;
        expected_results.push_back(sort_outcome(op_t'(opcode), value));
        items_accepted++;
      end
      if (cfg_we) begin
        moved = 1'b1;
        note_reg_write(cfg_index, cfg_wdata);
      end
      // watchdog on cycles with no transaction
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= WDOG_MAX) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  task automatic add_item(input op_t op, input logic [VALUE_W-1:0] v);
    pending_items.push_back('{op: op, val: v});
    items_queued++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // every item gives one result, so no result left means the block is idle
  task automatic wait_drained();
    while (items_accepted != items_queued || expected_results.size() != 0)
      @(negedge clk);
  endtask

  // mostly in range, a share on one hot bin, some noise over the full field
  function automatic logic [VALUE_W-1:0] pick_value(input int top, input int hot);
    int r;
    r = $urandom_range(99);
    if (r < 8) return VALUE_W'($urandom_range(BINS - 1, 0));
    if (r < 35) return VALUE_W'(hot);
    return VALUE_W'($urandom_range(top, 0));
  endfunction

  // bursts of inserts, each followed by a run of mostly fetches
  task automatic queue_sort_runs(input int n_items, input int top);
    int made;
    int burst;
    int hot;
    int k;
    made = 0;
    while (made < n_items) begin
      burst = $urandom_range(10, 1);
      hot   = $urandom_range(top, 0);
      for (k = 0; k < burst; k++) begin
        add_item(OP_INSERT, pick_value(top, hot));
        made++;
      end
      burst = $urandom_range(burst + 2, burst / 2);
      for (k = 0; k < burst; k++) begin
        if ($urandom_range(9) == 0) add_item(OP_INSERT, pick_value(top, hot));
        else add_item(OP_FETCH, VALUE_W'($urandom));
        made++;
      end
    end
  endtask

  initial begin
    int                  p;
    int                  k;
    logic [VALUE_W-1:0]  mv;
    logic [CFG_IDX_W-1:0] spare_idx;
    rst       = 1'b1;
    push      = 1'b0;
    pop       = 1'b0;
    opcode    = 1'b0;
    value     = '0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    item_taken     = 1'b0;
    items_queued   = 0;
    items_accepted = 0;
    error_count    = 0;
    quiet_cycles   = 0;
    idle_mode      = IDLE_NONE;
    for (k = 0; k < BINS; k++) bin_tally[k] = '0;
    top_reg  = MAX_VALUE_RESET;
    desc_reg = 1'b0;
    scan_at  = 0;

    repeat (5) @(negedge clk);
    rst <= 1'b0;

    // reset defaults: empty fetch, both field ends, insert during a run
    add_item(OP_FETCH,  10'd0);
    add_item(OP_INSERT, 10'd1023);
    add_item(OP_INSERT, 10'd0);
    add_item(OP_INSERT, 10'd1023);
    add_item(OP_FETCH,  10'd1023);
    add_item(OP_INSERT, 10'd512);
    add_item(OP_FETCH,  10'd0);
    add_item(OP_FETCH,  10'd0);
    add_item(OP_FETCH,  10'd0);
    add_item(OP_FETCH,  10'd0);
    wait_drained();

    // small top, descending, writes to unmapped indexes
    write_reg(CFG_MAX_VALUE, 10'd7);
    write_reg(CFG_DESCENDING, 10'd1);
    write_reg(REG_UNMAPPED_LO, 10'h3FF);
    write_reg(REG_UNMAPPED_HI, 10'h2AA);
    idle_mode = IDLE_BOTH;
    // pile several counts onto one bin, then values just over and at the top
    for (k = 0; k < 8; k++) add_item(OP_INSERT, 10'd3);
    add_item(OP_INSERT, 10'd8);
    add_item(OP_INSERT, 10'd7);
    add_item(OP_FETCH,  10'h3FF);
    add_item(OP_FETCH,  10'h155);
    add_item(OP_INSERT, 10'd1023);

    // random phases over top values and scan orders
    for (p = 0; p < 12; p++) begin
      case (p)
        0:       mv = 10'd0;
        3, 7:    mv = 10'd1023;
        10:      mv = 10'd1;
        default: mv = VALUE_W'($urandom_range(40, 2));
      endcase
      wait_drained();
      write_reg(CFG_MAX_VALUE, mv);
      write_reg(CFG_DESCENDING, {9'($urandom), 1'(p % 3 == 1)});
      if (p % 4 == 2) begin
        spare_idx = ($urandom_range(1) == 0) ? REG_UNMAPPED_LO : REG_UNMAPPED_HI;
        write_reg(spare_idx, VALUE_W'($urandom));
      end
      idle_mode = idle_mode_t'(p % 4);
      queue_sort_runs((mv >= 10'd512) ? 70 : 165, int'(mv));
    end

    wait_drained();
    repeat (50) @(negedge clk);
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/cse_pkg.sv
rtl/cse_ram.sv
rtl/cse_fifo.sv
rtl/cse_front.sv
rtl/cse_back.sv
rtl/counting_sort_engine.sv
tb/tb_top.sv
